@@ src/mpm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpm_pkg
// Shared widths, constants and types for the 2x2 matrix power unit that
// works modulo the prime 1000000007.
// ----------------------------------------------------------------------------
`default_nettype none

package mpm_pkg;

  // Field widths.
  localparam int RES_W     = 30;
  localparam int EXP_W     = 63;
  localparam int CFG_IDX_W = 2;

  // A 2x2 matrix has four entries, numbered row-major.
  localparam int NUM_ENT   = 4;
  localparam int ENT_IDX_W = 2;

  // The prime modulus.
  localparam logic [RES_W-1:0] MOD_P = 30'd1000000007;

  // Barrett constant floor(2^62 / MOD_P) for sums below 2^61.
  localparam int               MU_W       = 33;
  localparam logic [MU_W-1:0]  BARRETT_MU = 33'd4611685986;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_00 = 2'd0,
    REG_ENTRY_01 = 2'd1,
    REG_ENTRY_10 = 2'd2,
    REG_ENTRY_11 = 2'd3
  } cfg_reg_t;

  // Control that travels alongside one operation of the dot-product unit.
  typedef struct packed {
    logic                 vld;
    logic [ENT_IDX_W-1:0] idx;
  } mpm_tag_t;

  // Brings a 30-bit value into 0..MOD_P-1; one subtraction is enough.
  function automatic logic [RES_W-1:0] reduce_once(input logic [RES_W-1:0] v);
    logic [RES_W-1:0] d;
    d = v - MOD_P;
    return (v >= MOD_P) ? d : v;
  endfunction

endpackage

`default_nettype wire

@@ src/mpm_dot_mod.sv @@
// ----------------------------------------------------------------------------
// mpm_dot_mod
// Pipelined modular dot product: (a*b + c*d) mod MOD_P, one operation per
// cycle, registered result, Barrett reduction in the middle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpm_dot_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpm_pkg::mpm_tag_t             op_tag,
  input  logic [mpm_pkg::RES_W-1:0]     op_a,
  input  logic [mpm_pkg::RES_W-1:0]     op_b,
  input  logic [mpm_pkg::RES_W-1:0]     op_c,
  input  logic [mpm_pkg::RES_W-1:0]     op_d,
  output mpm_pkg::mpm_tag_t             res_tag,
  output logic [mpm_pkg::RES_W-1:0]     res_value
);

  localparam int LAT    = 6;
  localparam int RES_W  = mpm_pkg::RES_W;
  localparam int PROD_W = 2 * RES_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = 32;
  localparam int MU_W   = mpm_pkg::MU_W;
  localparam int QM_W   = Q_W + MU_W;
  localparam int QP_W   = Q_W + RES_W;
  localparam int R_W    = 32;

  localparam logic [R_W-1:0] P_R     = R_W'(mpm_pkg::MOD_P);
  localparam logic [R_W-1:0] TWO_P_R = P_R << 1;

  mpm_pkg::mpm_tag_t tag_r [LAT];

  logic [PROD_W-1:0] p0_r, p1_r;
  logic [SUM_W-1:0]  s2_r;
  logic [QM_W-1:0]   qm3_r;
  logic [R_W-1:0]    s3_r, s4_r;
  logic [R_W-1:0]    qp4_r;
  logic [R_W-1:0]    r5_r;
  logic [RES_W-1:0]  res6_r;

  logic [PROD_W-1:0] p0_full, p1_full;
  logic [QM_W-1:0]   qm_full;
  logic [Q_W-1:0]    q_est;
  logic [QP_W-1:0]   qp_full;
  logic [R_W-1:0]    r_sub1, r_sub2, r_fix;

  // Stage 1 products, stage 3 quotient estimate, stage 4 quotient times modulus.
  assign p0_full = {{RES_W{1'b0}}, op_a} * {{RES_W{1'b0}}, op_b};
  assign p1_full = {{RES_W{1'b0}}, op_c} * {{RES_W{1'b0}}, op_d};
  assign qm_full = {{MU_W{1'b0}}, s2_r[SUM_W-1:SUM_W-Q_W]}
                 * {{Q_W{1'b0}}, mpm_pkg::BARRETT_MU};
  assign q_est   = qm3_r[QM_W-1:MU_W];
  assign qp_full = {{RES_W{1'b0}}, q_est} * {{Q_W{1'b0}}, mpm_pkg::MOD_P};

  // The estimate is short by at most two, so the remainder is below 3*MOD_P.
  assign r_sub1 = r5_r - P_R;
  assign r_sub2 = r5_r - TWO_P_R;
  always_comb begin
    priority if (r5_r >= TWO_P_R) begin
      r_fix = r_sub2;
    end else if (r5_r >= P_R) begin
      r_fix = r_sub1;
    end else begin
      r_fix = r5_r;
    end
  end

  // Control pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        tag_r[k] <= '0;
      end
    end else begin
      tag_r[0] <= op_tag;
      for (int k = 1; k < LAT; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  // Data pipeline. Only the low 32 bits matter once the quotient is known.
  always_ff @(posedge clk) begin
    p0_r   <= p0_full;
    p1_r   <= p1_full;
    s2_r   <= {1'b0, p0_r} + {1'b0, p1_r};
    qm3_r  <= qm_full;
    s3_r   <= s2_r[R_W-1:0];
    qp4_r  <= qp_full[R_W-1:0];
    s4_r   <= s3_r;
    r5_r   <= s4_r - qp4_r;
    res6_r <= r_fix[RES_W-1:0];
  end

  assign res_tag   = tag_r[LAT-1];
  assign res_value = res6_r;

endmodule

`default_nettype wire

@@ src/matrix_power_mod_prime.sv @@
// ----------------------------------------------------------------------------
// matrix_power_mod_prime
// Raises a configured 2x2 matrix to an input exponent modulo 1000000007 by
// square-and-multiply, most significant exponent bit first.
// ----------------------------------------------------------------------------
// One exponent word at a time is taken; the block stalls its input until the
// result has been moved to the output register. Every matrix product issues
// its four entries to one shared six-stage modular dot-product unit, waits
// for the four results and commits them. An item costs EXP_BITS squarings
// (63 by default) plus one multiply per set exponent bit. Exponent bits at or
// above EXP_BITS are ignored, and entry registers at or above the modulus are
// reduced before use.
`default_nettype none

module matrix_power_mod_prime #(
  parameter int EXP_BITS = 63
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpm_pkg::RES_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mpm_pkg::EXP_W-1:0]         in_exponent,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mpm_pkg::RES_W-1:0]         out_power_00,
  output logic [mpm_pkg::RES_W-1:0]         out_power_01,
  output logic [mpm_pkg::RES_W-1:0]         out_power_10,
  output logic [mpm_pkg::RES_W-1:0]         out_power_11
);

  localparam int RES_W   = mpm_pkg::RES_W;
  localparam int NUM_ENT = mpm_pkg::NUM_ENT;
  localparam int IDX_W   = mpm_pkg::ENT_IDX_W;
  localparam int CNT_W   = $clog2(EXP_BITS);
  localparam int RET_W   = $clog2(NUM_ENT + 1);

  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(EXP_BITS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ENT - 1);
  localparam logic [RET_W-1:0] RET_ALL  = RET_W'(NUM_ENT);

  // Reset values of the entries; row 1 column 0 is minus one.
  localparam logic [RES_W-1:0] RST_00 = 30'd3;
  localparam logic [RES_W-1:0] RST_01 = 30'd1;
  localparam logic [RES_W-1:0] RST_10 = mpm_pkg::MOD_P - 30'd1;
  localparam logic [RES_W-1:0] RST_11 = 30'd0;

  localparam logic [RES_W-1:0] ONE  = 30'd1;
  localparam logic [RES_W-1:0] ZERO = 30'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              phase_mul_r;
  logic [IDX_W-1:0]  idx_r;
  logic [RET_W-1:0]  ret_cnt_r;
  logic              out_valid_r;

  logic [RES_W-1:0]    entry_r [NUM_ENT];
  logic [RES_W-1:0]    base_r  [NUM_ENT];
  logic [RES_W-1:0]    acc_r   [NUM_ENT];
  logic [RES_W-1:0]    res_r   [NUM_ENT];
  logic [EXP_BITS-1:0] exp_r;
  logic [RES_W-1:0]    pow_r   [NUM_ENT];

  logic              in_accept;
  logic              commit;
  mpm_pkg::mpm_tag_t op_tag, res_tag;
  logic [RES_W-1:0]  op_a, op_b, op_c, op_d;
  logic [RES_W-1:0]  y0, y1, y2, y3;
  logic [RES_W-1:0]  res_value;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign commit    = (state_r == ST_WAIT) && (ret_cnt_r == RET_ALL);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r[0] <= RST_00;
      entry_r[1] <= RST_01;
      entry_r[2] <= RST_10;
      entry_r[3] <= RST_11;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpm_pkg::REG_ENTRY_00: entry_r[0] <= cfg_wdata;
        mpm_pkg::REG_ENTRY_01: entry_r[1] <= cfg_wdata;
        mpm_pkg::REG_ENTRY_10: entry_r[2] <= cfg_wdata;
        mpm_pkg::REG_ENTRY_11: entry_r[3] <= cfg_wdata;
      endcase
    end
  end

  // Operand selection: squaring uses the accumulator twice, the multiply
  // step takes the base as the right-hand factor.
  assign y0 = phase_mul_r ? base_r[0] : acc_r[0];
  assign y1 = phase_mul_r ? base_r[1] : acc_r[1];
  assign y2 = phase_mul_r ? base_r[2] : acc_r[2];
  assign y3 = phase_mul_r ? base_r[3] : acc_r[3];

  always_comb begin
    unique case (idx_r)
      2'd0: begin
        op_a = acc_r[0]; op_b = y0; op_c = acc_r[1]; op_d = y2;
      end
      2'd1: begin
        op_a = acc_r[0]; op_b = y1; op_c = acc_r[1]; op_d = y3;
      end
      2'd2: begin
        op_a = acc_r[2]; op_b = y0; op_c = acc_r[3]; op_d = y2;
      end
      default: begin
        op_a = acc_r[2]; op_b = y1; op_c = acc_r[3]; op_d = y3;
      end
    endcase
  end

  assign op_tag.vld = (state_r == ST_ISSUE);
  assign op_tag.idx = idx_r;

  mpm_dot_mod u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_tag    (op_tag),
    .op_a      (op_a),
    .op_b      (op_b),
    .op_c      (op_c),
    .op_d      (op_d),
    .res_tag   (res_tag),
    .res_value (res_value)
  );

  // Matrix storage: base and identity are loaded on accept, product entries
  // are collected and committed once all four are back.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        base_r[k] <= mpm_pkg::reduce_once(entry_r[k]);
      end
      acc_r[0] <= ONE;
      acc_r[1] <= ZERO;
      acc_r[2] <= ZERO;
      acc_r[3] <= ONE;
      exp_r    <= in_exponent[EXP_BITS-1:0];
    end
    if (res_tag.vld) begin
      res_r[res_tag.idx] <= res_value;
    end
    if (commit) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        acc_r[k] <= res_r[k];
      end
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      phase_mul_r <= 1'b0;
      idx_r       <= '0;
      ret_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The output word is set when a result is loaded and cleared once taken.
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r     <= ST_ISSUE;
            cnt_r       <= CNT_INIT;
            phase_mul_r <= 1'b0;
            idx_r       <= '0;
            ret_cnt_r   <= '0;
          end
        end
        ST_ISSUE: begin
          idx_r <= idx_r + IDX_W'(1);
          if (idx_r == IDX_LAST) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (ret_cnt_r == RET_ALL) begin
            ret_cnt_r <= '0;
            idx_r     <= '0;
            priority if (!phase_mul_r && exp_r[cnt_r]) begin
              phase_mul_r <= 1'b1;
              state_r     <= ST_ISSUE;
            end else if (cnt_r == '0) begin
              state_r <= ST_DONE;
            end else begin
              cnt_r       <= cnt_r - CNT_W'(1);
              phase_mul_r <= 1'b0;
              state_r     <= ST_ISSUE;
            end
          end else if (res_tag.vld) begin
            ret_cnt_r <= ret_cnt_r + RET_W'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            for (int k = 0; k < NUM_ENT; k++) begin
              pow_r[k] <= acc_r[k];
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_power_00 = pow_r[0];
  assign out_power_01 = pow_r[1];
  assign out_power_10 = pow_r[2];
  assign out_power_11 = pow_r[3];

`ifndef SYNTHESIS
  // Results from the shared unit only come back while the sequencer waits.
  a_res_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res_tag.vld |-> state_r == ST_WAIT)
    else $error("dot-product result outside the wait state");

  // No more results come back than entries were issued.
  a_ret_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ret_cnt_r <= RET_ALL)
    else $error("too many dot-product results");

  // A presented word is fully reduced.
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pow_r[0] < mpm_pkg::MOD_P) && (pow_r[1] < mpm_pkg::MOD_P) &&
                    (pow_r[2] < mpm_pkg::MOD_P) && (pow_r[3] < mpm_pkg::MOD_P))
    else $error("output entry not reduced");

  // An accepted word starts with a squaring at the top exponent bit.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_ISSUE && cnt_r == CNT_INIT && !phase_mul_r &&
                  idx_r == '0)
    else $error("bad start of exponentiation");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for matrix_power_mod_prime
// Streams exponent words through the matrix power unit under several entry
// settings and compares every result word with a cycle-free software
// square-and-multiply over the same residues.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RES_W       = mpm_pkg::RES_W;
  localparam int          EXP_W       = mpm_pkg::EXP_W;
  localparam int          NUM_ENT     = mpm_pkg::NUM_ENT;
  localparam int          CFG_IDX_W   = mpm_pkg::CFG_IDX_W;
  localparam int          EXP_BITS    = 63;
  localparam logic [63:0] PRIME       = 64'(mpm_pkg::MOD_P);
  localparam int          CYCLE_LIMIT = 6000000;
  localparam int          TAIL_CYCLES = 1300;

  // Patterns the receiver cycles through.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_e;

  // One 2x2 matrix of residues, row-major.
  typedef struct packed {
    logic [RES_W-1:0] e00;
    logic [RES_W-1:0] e01;
    logic [RES_W-1:0] e10;
    logic [RES_W-1:0] e11;
  } mat2_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RES_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [EXP_W-1:0] in_exponent;
  logic             out_valid;
  logic             out_stall;
  logic [RES_W-1:0] out_power_00;
  logic [RES_W-1:0] out_power_01;
  logic [RES_W-1:0] out_power_10;
  logic [RES_W-1:0] out_power_11;

  // Shadow copy of the entry registers as last written.
  logic [RES_W-1:0] entry_q [NUM_ENT];

  logic [EXP_W-1:0] pending_exponents [$];
  mat2_t            expected_powers [$];

  int          fail_count = 0;
  int          result_count = 0;
  int          cycle_count = 0;
  int          burst_left;
  int          gap_left;
  stall_mode_e stall_mode;
  int          mode_left;
  int          run_left;
  bit          run_level;

  matrix_power_mod_prime #(.EXP_BITS(EXP_BITS)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_power_00 (out_power_00),
    .out_power_01 (out_power_01),
    .out_power_10 (out_power_10),
    .out_power_11 (out_power_11)
  );

  always #10 clk = ~clk;

  // Sum of two residue products, reduced; each product is below 2^60.
  function automatic logic [RES_W-1:0] dot_mod(input logic [RES_W-1:0] a,
                                               input logic [RES_W-1:0] b,
                                               input logic [RES_W-1:0] c,
                                               input logic [RES_W-1:0] d);
    logic [63:0] s;
    s = 64'(a) * 64'(b) + 64'(c) * 64'(d);
    return RES_W'(s % PRIME);
  endfunction

  function automatic mat2_t mat_product(input mat2_t x, input mat2_t y);
    mat2_t r;
    r.e00 = dot_mod(x.e00, y.e00, x.e01, y.e10);
    r.e01 = dot_mod(x.e00, y.e01, x.e01, y.e11);
    r.e10 = dot_mod(x.e10, y.e00, x.e11, y.e10);
    r.e11 = dot_mod(x.e10, y.e01, x.e11, y.e11);
    return r;
  endfunction

  function automatic logic [RES_W-1:0] residue(input logic [RES_W-1:0] v);
    return RES_W'(64'(v) % PRIME);
  endfunction

  // Square-and-multiply from the top exponent bit down; zero gives identity.
  function automatic mat2_t matrix_power(input logic [EXP_W-1:0] ex);
    mat2_t base_m;
    mat2_t acc;
    base_m.e00 = residue(entry_q[mpm_pkg::REG_ENTRY_00]);
    base_m.e01 = residue(entry_q[mpm_pkg::REG_ENTRY_01]);
    base_m.e10 = residue(entry_q[mpm_pkg::REG_ENTRY_10]);
    base_m.e11 = residue(entry_q[mpm_pkg::REG_ENTRY_11]);
    acc = {30'd1, 30'd0, 30'd0, 30'd1};
    for (int b = EXP_BITS - 1; b >= 0; b--) begin
      acc = mat_product(acc, acc);
      if (ex[b]) acc = mat_product(acc, base_m);
    end
    return acc;
  endfunction

  // Small and mid-sized exponents, full-width ones, and sparse and dense ones.
  function automatic logic [EXP_W-1:0] pick_exponent();
    logic [63:0]      r;
    logic [EXP_W-1:0] e;
    int               k;
    r = {$urandom(), $urandom()};
    e = r[EXP_W-1:0];
    k = $urandom_range(0, 99);
    if (k < 30) begin
      e = EXP_W'($urandom_range(0, 255));
    end else if (k < 45) begin
      e = e >> $urandom_range(8, 56);
    end else if (k < 55) begin
      e = EXP_W'(1) << $urandom_range(0, EXP_W - 1);
    end else if (k < 62) begin
      e = {EXP_W{1'b1}} ^ (EXP_W'(1) << $urandom_range(0, EXP_W - 1));
    end
    return e;
  endfunction

  // Entry values: small, around the modulus, near the top of 30 bits, or any.
  function automatic logic [RES_W-1:0] pick_entry();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return RES_W'($urandom_range(0, 3));
    if (k < 4) return mpm_pkg::MOD_P - 30'd3 + RES_W'($urandom_range(0, 6));
    if (k < 5) return 30'h3FFF_FFFF - RES_W'($urandom_range(0, 3));
    return RES_W'($urandom());
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return $urandom_range(0, 5);
    if (k < 9) return $urandom_range(6, 60);
    return $urandom_range(61, 1300);
  endfunction

  task automatic write_entry(input mpm_pkg::cfg_reg_t idx, input logic [RES_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    entry_q[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_matrix(input logic [RES_W-1:0] v00, input logic [RES_W-1:0] v01,
                            input logic [RES_W-1:0] v10, input logic [RES_W-1:0] v11);
    write_entry(mpm_pkg::REG_ENTRY_00, v00);
    write_entry(mpm_pkg::REG_ENTRY_01, v01);
    write_entry(mpm_pkg::REG_ENTRY_10, v10);
    write_entry(mpm_pkg::REG_ENTRY_11, v11);
  endtask

  // Wait until every word is sent and every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_exponents.size() != 0 || in_valid || expected_powers.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int n_random, input bit with_edges);
    @(negedge clk);
    if (with_edges) begin
      pending_exponents.push_back('0);
      pending_exponents.push_back({EXP_W{1'b1}});
    end
    repeat (n_random) pending_exponents.push_back(pick_exponent());
    wait_drained();
  endtask

  // Stimulus sequence: reset matrix, extreme settings, then random settings.
  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = mpm_pkg::REG_ENTRY_00;
    cfg_wdata   = '0;
    entry_q[mpm_pkg::REG_ENTRY_00] = 30'd3;
    entry_q[mpm_pkg::REG_ENTRY_01] = 30'd1;
    entry_q[mpm_pkg::REG_ENTRY_10] = mpm_pkg::MOD_P - 30'd1;
    entry_q[mpm_pkg::REG_ENTRY_11] = 30'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words against the matrix left by reset.
    @(negedge clk);
    pending_exponents.push_back(63'd0);
    pending_exponents.push_back(63'd1);
    pending_exponents.push_back(63'd2);
    pending_exponents.push_back(63'd3);
    pending_exponents.push_back(63'd7);
    pending_exponents.push_back({EXP_W{1'b1}});
    pending_exponents.push_back(63'h4000_0000_0000_0000);
    pending_exponents.push_back(63'h4000_0000_0000_0001);
    pending_exponents.push_back(63'h2AAA_AAAA_AAAA_AAAA);
    pending_exponents.push_back(63'h5555_5555_5555_5555);
    pending_exponents.push_back(63'd1000000006);
    pending_exponents.push_back(63'd1000000007);
    pending_exponents.push_back(63'd1000000008);
    pending_exponents.push_back(63'h0000_0000_FFFF_FFFF);
    run_phase(20, 1'b0);

    // Extreme entries: all zero, all minus one, all-ones above the modulus,
    // and exactly the modulus, which reduces to zero.
    set_matrix('0, '0, '0, '0);
    run_phase(40, 1'b1);
    set_matrix(mpm_pkg::MOD_P - 30'd1, mpm_pkg::MOD_P - 30'd1,
               mpm_pkg::MOD_P - 30'd1, mpm_pkg::MOD_P - 30'd1);
    run_phase(40, 1'b1);
    set_matrix(30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF);
    run_phase(40, 1'b1);
    set_matrix(mpm_pkg::MOD_P, mpm_pkg::MOD_P, mpm_pkg::MOD_P, mpm_pkg::MOD_P);
    run_phase(40, 1'b1);

    repeat (8) begin
      set_matrix(pick_entry(), pick_entry(), pick_entry(), pick_entry());
      run_phase(50, 1'b0);
    end

    // Any stray word after the last expected one shows up as unexpected.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_exponent <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_powers.push_back(matrix_power(in_exponent));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_exponents.size() > 0) begin
          in_valid    <= 1'b1;
          in_exponent <= pending_exponents.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 7);
            gap_left   = pick_gap();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between quiet, light, heavy and runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode = STALL_NONE;
      mode_left  = 0;
      run_left   = 0;
      run_level  = 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(400, 4000);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            run_level = !run_level;
            run_left  = run_level ? $urandom_range(1, 40) : $urandom_range(1, 10);
          end else begin
            run_left--;
          end
          out_stall <= run_level;
        end
      endcase
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    mat2_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_powers.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word %0d: %0d %0d %0d %0d", result_count,
                   out_power_00, out_power_01, out_power_10, out_power_11);
      end else begin
        want = expected_powers.pop_front();
        if (out_power_00 !== want.e00 || out_power_01 !== want.e01 ||
            out_power_10 !== want.e10 || out_power_11 !== want.e11) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"power mismatch on result %0d: ",
                      "expected %0d %0d %0d %0d, got %0d %0d %0d %0d"},
                     result_count, want.e00, want.e01, want.e10, want.e11,
                     out_power_00, out_power_01, out_power_10, out_power_11);
        end
      end
      result_count++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

@@ matrix_power_mod_prime.f @@
src/mpm_pkg.sv
src/mpm_dot_mod.sv
src/matrix_power_mod_prime.sv
sim/testbench.sv
